// ===== design/qts_pkg.sv =====
// Package for the quoted token splitter: widths, codes, payload types and reset values.
`default_nettype none

package qts_pkg;

  localparam int UNIT_W         = 16;
  localparam int COUNT_W        = 3;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 16;
  localparam int NUM_DELIM_REGS = 4;
  localparam int DEF_MAX_DELIMS = 4;
  localparam int DEF_UNIT_BITS  = 16;

  localparam int MAX_RESULTS = 4;
  localparam int RES_IDX_W   = 2;
  localparam int GRP_DEPTH   = 2;
  localparam int GRP_PTR_W   = 1;
  localparam int GRP_CNT_W   = 2;

  localparam logic [UNIT_W-1:0] CU_DQUOTE = 16'd34;
  localparam logic [UNIT_W-1:0] CU_SQUOTE = 16'd39;
  localparam logic [UNIT_W-1:0] CU_BSLASH = 16'd92;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BASE  = 8'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd1;
  localparam logic [UNIT_W-1:0]  DELIM_RESET [NUM_DELIM_REGS] =
    '{16'd32, 16'd9, 16'd44, 16'd59};

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_TEND      = 2'd1,
    KIND_OK        = 2'd2,
    KIND_UNMATCHED = 2'd3
  } kind_e;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              is_final;
  } in_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [UNIT_W-1:0] char_out;
    logic              run_end;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [UNIT_W-1:0] ch;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [RES_IDX_W-1:0]      last;
  } grp_t;

endpackage

`default_nettype wire

// ===== design/qts_stream_if.sv =====
// Valid/ready channel interface carrying one payload item.
`default_nettype none

interface qts_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/quoted_token_splitter.sv =====
// Results of an accepted item are registered into the group queue that feeds out_o.
// Throughput: one item per cycle while each item yields at most one result and
// out_o is ready; an item with more results holds the output until all are taken,
// buffered in a 2-entry group queue. Input ready drops only when the queue is full.
// Reset: quote/escape/token state cleared, delimiters to defaults, queue emptied.
`default_nettype none

module quoted_token_splitter #(
  parameter int MAX_DELIMS = qts_pkg::DEF_MAX_DELIMS,
  parameter int UNIT_BITS  = qts_pkg::DEF_UNIT_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  qts_stream_if.sink    cfg_i,
  qts_stream_if.sink    in_i,
  qts_stream_if.source  out_o
);
  import qts_pkg::*;

  localparam int NREG     = (MAX_DELIMS < NUM_DELIM_REGS) ? MAX_DELIMS : NUM_DELIM_REGS;
  localparam int CMP_BITS = (UNIT_BITS < UNIT_W) ? UNIT_BITS : UNIT_W;
  localparam logic [UNIT_W-1:0] CMP_MASK = UNIT_W'((64'd1 << CMP_BITS) - 64'd1);

  typedef enum logic [1:0] {
    QM_OUT = 2'd0,
    QM_DQ  = 2'd1,
    QM_SQ  = 2'd2
  } qmode_e;

  typedef struct packed {
    logic              emit;
    kind_e             kind;
    logic [UNIT_W-1:0] ch;
    qmode_e            qm;
    logic              open;
  } plain_t;

  function automatic plain_t plain_unit(input logic [UNIT_W-1:0] u, input qmode_e qm,
                                        input logic open, input logic dl);
    plain_t p;
    p.emit = 1'b0;
    p.kind = KIND_CHAR;
    p.ch   = u;
    p.qm   = qm;
    p.open = open;
    if (qm == QM_OUT) begin
      if (u == CU_DQUOTE) begin
        p.qm = QM_DQ;
      end else if (u == CU_SQUOTE) begin
        p.qm = QM_SQ;
      end else if (dl) begin
        if (open) begin
          p.emit = 1'b1;
          p.kind = KIND_TEND;
          p.ch   = '0;
          p.open = 1'b0;
        end
      end else begin
        p.emit = 1'b1;
        p.open = 1'b1;
      end
    end else if ((qm == QM_DQ && u == CU_DQUOTE) || (qm == QM_SQ && u == CU_SQUOTE)) begin
      p.qm = QM_OUT;
    end else begin
      p.emit = 1'b1;
      p.open = 1'b1;
    end
    return p;
  endfunction

  // config registers
  logic [COUNT_W-1:0] delim_count_q;
  logic [UNIT_W-1:0]  delim_q [NREG];

  // parse state
  qmode_e qm_q, qm_d;
  logic   held_q, held_d;
  logic   open_q, open_d;

  // group queue
  grp_t                 grp_q [GRP_DEPTH];
  grp_t                 grp_d;
  logic [GRP_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [GRP_CNT_W-1:0] fill_q;
  logic [RES_IDX_W-1:0] sub_q;

  logic [UNIT_W-1:0]  u;
  logic               fin;
  logic               hit_u, hit_bs;
  logic               esc;
  logic               consumed;
  logic [RES_IDX_W:0] n_cnt;
  plain_t             p1, p2;
  logic               in_acc, out_acc, push, pop;
  grp_t               head;

  assign u   = in_i.data.code_unit & CMP_MASK;
  assign fin = in_i.data.is_final;

  always_comb begin
    hit_u  = 1'b0;
    hit_bs = 1'b0;
    for (int i = 0; i < NREG; i++) begin
      if (COUNT_W'(i) < delim_count_q) begin
        if ((delim_q[i] & CMP_MASK) == u) hit_u = 1'b1;
        if ((delim_q[i] & CMP_MASK) == (CU_BSLASH & CMP_MASK)) hit_bs = 1'b1;
      end
    end
  end

  assign esc = held_q && ((qm_q == QM_OUT && (u == CU_DQUOTE || u == CU_SQUOTE)) ||
                          (qm_q == QM_DQ && u == CU_DQUOTE) ||
                          (qm_q == QM_SQ && u == CU_SQUOTE));

  always_comb begin
    grp_d    = '0;
    n_cnt    = '0;
    qm_d     = qm_q;
    open_d   = open_q;
    held_d   = 1'b0;
    consumed = 1'b0;
    p1       = plain_unit(CU_BSLASH & CMP_MASK, qm_q, open_q, hit_bs);
    if (held_q) begin
      if (esc) begin
        grp_d.res[n_cnt[RES_IDX_W-1:0]] = '{kind: KIND_CHAR, ch: u};
        n_cnt    = n_cnt + 1'b1;
        open_d   = 1'b1;
        consumed = 1'b1;
      end else begin
        qm_d   = p1.qm;
        open_d = p1.open;
        if (p1.emit) begin
          grp_d.res[n_cnt[RES_IDX_W-1:0]] = '{kind: p1.kind, ch: p1.ch};
          n_cnt = n_cnt + 1'b1;
        end
      end
    end
    p2 = plain_unit(u, qm_d, open_d, hit_u);
    if (!consumed) begin
      if (u == (CU_BSLASH & CMP_MASK) && !fin) begin
        held_d = 1'b1;
      end else begin
        qm_d   = p2.qm;
        open_d = p2.open;
        if (p2.emit) begin
          grp_d.res[n_cnt[RES_IDX_W-1:0]] = '{kind: p2.kind, ch: p2.ch};
          n_cnt = n_cnt + 1'b1;
        end
      end
    end
    if (fin) begin
      if (open_d) begin
        grp_d.res[n_cnt[RES_IDX_W-1:0]] = '{kind: KIND_TEND, ch: '0};
        n_cnt = n_cnt + 1'b1;
      end
      grp_d.res[n_cnt[RES_IDX_W-1:0]] =
        '{kind: (qm_d == QM_OUT) ? KIND_OK : KIND_UNMATCHED, ch: '0};
      n_cnt  = n_cnt + 1'b1;
      qm_d   = QM_OUT;
      held_d = 1'b0;
      open_d = 1'b0;
    end
    grp_d.last = RES_IDX_W'(n_cnt - 1'b1);
  end

  assign in_i.ready  = (fill_q != GRP_CNT_W'(GRP_DEPTH));
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign push        = in_acc && (n_cnt != '0);

  assign head               = grp_q[rd_ptr_q];
  assign out_o.valid        = (fill_q != '0);
  assign out_o.data.kind     = head.res[sub_q].kind;
  assign out_o.data.char_out = head.res[sub_q].ch;
  assign out_o.data.run_end  = (sub_q == head.last);
  assign out_acc            = out_o.valid && out_o.ready;
  assign pop                = out_acc && (sub_q == head.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_count_q <= COUNT_RESET;
      for (int i = 0; i < NREG; i++) delim_q[i] <= DELIM_RESET[i];
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.data.index == REG_DELIM_COUNT) begin
        delim_count_q <= cfg_i.data.value[COUNT_W-1:0];
      end
      for (int i = 0; i < NREG; i++) begin
        if (cfg_i.data.index == REG_DELIM_BASE + CFG_IDX_W'(i)) begin
          delim_q[i] <= cfg_i.data.value[UNIT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qm_q     <= QM_OUT;
      held_q   <= 1'b0;
      open_q   <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      sub_q    <= '0;
    end else begin
      if (in_acc) begin
        qm_q   <= qm_d;
        held_q <= held_d;
        open_q <= open_d;
      end
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
        sub_q    <= '0;
      end else if (out_acc) begin
        sub_q <= sub_q + 1'b1;
      end
      fill_q <= fill_q + GRP_CNT_W'(push) - GRP_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) grp_q[wr_ptr_q] <= grp_d;
  end

endmodule

`default_nettype wire

// ===== design/qts_checker.sv =====
// Port-level assertions for the quoted token splitter, bound into each instance of it.
`default_nettype none

module qts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input qts_pkg::out_item_t out_data_i
);
  import qts_pkg::*;

  logic last_tend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_tend_q <= 1'b0;
    end else if (out_valid_i && out_ready_i) begin
      last_tend_q <= (out_data_i.kind == KIND_TEND);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output item changed while stalled");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.kind == KIND_OK || out_data_i.kind == KIND_UNMATCHED)
    |-> out_data_i.run_end)
    else $error("string status is not the last result of its item");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind != KIND_CHAR |-> out_data_i.char_out == '0)
    else $error("nonzero char on a non-character result");

  a_no_empty_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_tend_q |-> out_data_i.kind != KIND_TEND)
    else $error("empty token emitted");

endmodule

bind quoted_token_splitter qts_checker u_qts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

// ===== tb/quoted_token_splitter_test.sv =====
// Testbench for quoted_token_splitter: directed table plus random strings, checked by a predictor.
`timescale 1ns / 100ps

module quoted_token_splitter_test;
  import qts_pkg::*;

  typedef enum logic [1:0] {
    QM_NONE   = 2'd0,
    QM_DOUBLE = 2'd1,
    QM_SINGLE = 2'd2
  } qmode_e;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              fin;
    logic              typed;
    logic [1:0]        n;
    result_t [0:2]     res;
  } dir_row_t;

  localparam result_t NIL_RES = '{kind: KIND_CHAR, ch: '0};
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW =
    REG_DELIM_BASE + CFG_IDX_W'(NUM_DELIM_REGS);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = '1;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 8;
  localparam int PHASE_UNITS   = 55;

  logic clk;
  logic rst_n = 1'b0;

  qts_stream_if #(.T(cfg_item_t)) cfg_ch ();
  qts_stream_if #(.T(in_item_t))  in_ch ();
  qts_stream_if #(.T(out_item_t)) out_ch ();

  quoted_token_splitter DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // splitter state and register copy
  qmode_e            qmode = QM_NONE;
  logic              bs_held = 1'b0;
  logic              tok_open = 1'b0;
  logic [COUNT_W-1:0] delim_count_m = COUNT_RESET;
  logic [UNIT_W-1:0] delim_units [NUM_DELIM_REGS];

  out_item_t         step_out[$];
  out_item_t         pending_results[$];
  dir_row_t          dir_tab[$];
  logic [UNIT_W-1:0] str_q[$];

  int cur_row = -1;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int n_fail = 0;
  int n_checked = 0;
  int n_units = 0;
  int n_strings = 0;
  int n_settings = 1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic bit is_delim_unit(logic [UNIT_W-1:0] u);
    int lim;
    lim = (delim_count_m > NUM_DELIM_REGS) ? NUM_DELIM_REGS : delim_count_m;
    for (int i = 0; i < lim; i++) begin
      if (delim_units[i] == u) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [UNIT_W-1:0] open_quote();
    return (qmode == QM_DOUBLE) ? CU_DQUOTE : CU_SQUOTE;
  endfunction

  function automatic void add_result(kind_e k, logic [UNIT_W-1:0] ch);
    out_item_t r;
    r.kind = k;
    r.char_out = (k == KIND_CHAR) ? ch : '0;
    r.run_end = 1'b0;
    step_out = {step_out, r};
    if (k == KIND_CHAR) tok_open = 1'b1;
  endfunction

  function automatic void add_unit(logic [UNIT_W-1:0] v);
    str_q = {str_q, v};
  endfunction

  function automatic void add_row(dir_row_t d);
    dir_tab = {dir_tab, d};
  endfunction

  function automatic void plain_unit(logic [UNIT_W-1:0] u);
    if (qmode == QM_NONE) begin
      if (u == CU_DQUOTE) begin
        qmode = QM_DOUBLE;
      end else if (u == CU_SQUOTE) begin
        qmode = QM_SINGLE;
      end else if (is_delim_unit(u)) begin
        if (tok_open) begin
          add_result(KIND_TEND, '0);
          tok_open = 1'b0;
        end
      end else begin
        add_result(KIND_CHAR, u);
      end
    end else if (u == open_quote()) begin
      qmode = QM_NONE;
    end else begin
      add_result(KIND_CHAR, u);
    end
  endfunction

  function automatic void split_step(logic [UNIT_W-1:0] u, logic fin);
    bit taken;
    taken = 1'b0;
    step_out.delete();
    if (bs_held) begin
      bs_held = 1'b0;
      if ((qmode == QM_NONE && (u == CU_DQUOTE || u == CU_SQUOTE)) ||
          (qmode != QM_NONE && u == open_quote())) begin
        add_result(KIND_CHAR, u);
        taken = 1'b1;
      end else begin
        plain_unit(CU_BSLASH);
      end
    end
    if (!taken) begin
      if (u == CU_BSLASH && !fin) bs_held = 1'b1;
      else plain_unit(u);
    end
    if (fin) begin
      if (tok_open) add_result(KIND_TEND, '0);
      add_result((qmode == QM_NONE) ? KIND_OK : KIND_UNMATCHED, '0);
      qmode = QM_NONE;
      bs_held = 1'b0;
      tok_open = 1'b0;
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].run_end = 1'b1;
  endfunction

  function automatic result_t rs(kind_e k, logic [UNIT_W-1:0] c);
    return '{kind: k, ch: c};
  endfunction

  function automatic dir_row_t pr(logic [UNIT_W-1:0] u, logic f);
    return '{unit: u, fin: f, typed: 1'b0, n: 2'd0, res: {NIL_RES, NIL_RES, NIL_RES}};
  endfunction

  function automatic dir_row_t ty(logic [UNIT_W-1:0] u, logic f, logic [1:0] n,
                                  result_t r0, result_t r1, result_t r2);
    return '{unit: u, fin: f, typed: 1'b1, n: n, res: {r0, r1, r2}};
  endfunction

  function automatic logic [UNIT_W-1:0] letter_unit();
    if ($urandom_range(0, 9) == 0) return UNIT_W'($urandom);
    return UNIT_W'(97 + $urandom_range(0, 25));
  endfunction

  function automatic logic [UNIT_W-1:0] delim_unit();
    int lim;
    lim = (delim_count_m > NUM_DELIM_REGS) ? NUM_DELIM_REGS : delim_count_m;
    if (lim == 0) return DELIM_RESET[$urandom_range(0, NUM_DELIM_REGS - 1)];
    return delim_units[$urandom_range(0, lim - 1)];
  endfunction

  function automatic logic [UNIT_W-1:0] any_unit();
    case ($urandom_range(0, 7))
      0: return letter_unit();
      1: return delim_unit();
      2: return CU_DQUOTE;
      3: return CU_SQUOTE;
      4: return CU_BSLASH;
      5: return '0;
      6: return '1;
      default: return UNIT_W'($urandom);
    endcase
  endfunction

  // mostly well-formed strings: words, delimiters, closed quoted runs, escapes
  function automatic void build_string();
    logic [UNIT_W-1:0] q;
    str_q.delete();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 8)) add_unit(any_unit());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 5))
          0, 1: repeat ($urandom_range(1, 4)) add_unit(letter_unit());
          2: add_unit(delim_unit());
          3: begin
            q = $urandom_range(0, 1) ? CU_DQUOTE : CU_SQUOTE;
            add_unit(q);
            repeat ($urandom_range(0, 4)) begin
              case ($urandom_range(0, 3))
                0: add_unit(letter_unit());
                1: add_unit(delim_unit());
                2: begin
                  add_unit(CU_BSLASH);
                  add_unit(q);
                end
                default: add_unit((q == CU_DQUOTE) ? CU_SQUOTE : CU_DQUOTE);
              endcase
            end
            add_unit(q);
          end
          4: begin
            add_unit(CU_BSLASH);
            add_unit($urandom_range(0, 1) ? CU_DQUOTE : CU_SQUOTE);
          end
          default: begin
            add_unit(CU_BSLASH);
            add_unit($urandom_range(0, 1) ? letter_unit() : delim_unit());
          end
        endcase
      end
    end
  endfunction

  task automatic send_unit(input logic [UNIT_W-1:0] u, input logic fin, input int row);
    if (burst_left == 0) begin
      if (gaps_on) begin
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk);
          in_ch.valid <= 1'b0;
        end
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{code_unit: u, is_final: fin};
    cur_row     <= row;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain(input int settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    cur_row     <= -1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.data.index == REG_DELIM_COUNT) begin
        delim_count_m = cfg_ch.data.value[COUNT_W-1:0];
      end else if (cfg_ch.data.index >= REG_DELIM_BASE &&
                   cfg_ch.data.index < REG_DELIM_BASE + NUM_DELIM_REGS) begin
        delim_units[2'(cfg_ch.data.index - REG_DELIM_BASE)] = cfg_ch.data.value;
      end
    end
  end

  always @(posedge clk) begin : track_units
    dir_row_t  row;
    out_item_t r;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      split_step(in_ch.data.code_unit, in_ch.data.is_final);
      n_units++;
      if (in_ch.data.is_final) n_strings++;
      if (cur_row >= 0 && dir_tab[cur_row].typed) begin
        row = dir_tab[cur_row];
        for (int i = 0; i < row.n; i++) begin
          r.kind     = row.res[i].kind;
          r.char_out = row.res[i].ch;
          r.run_end  = (i == row.n - 1);
          pending_results = {pending_results, r};
        end
      end else begin
        foreach (step_out[i]) pending_results = {pending_results, step_out[i]};
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      n_checked++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d char_out %h run_end %0d",
               got.kind, got.char_out, got.run_end);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, got.kind);
          n_fail++;
        end
        if (got.char_out !== want.char_out) begin
          $error("char_out: expected %h, got %h", want.char_out, got.char_out);
          n_fail++;
        end
        if (got.run_end !== want.run_end) begin
          $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
          n_fail++;
        end
      end
    end
  end

  initial begin : rx_stall
    int mode;
    int left;
    int cyc;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    cyc  = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 150);
      end
      left--;
      cyc++;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= (cyc % 4 == 0);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin : stimulus
    int phase_units;
    int wait_cycles;
    bit paused;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    for (int i = 0; i < NUM_DELIM_REGS; i++) delim_units[i] = DELIM_RESET[i];

    // reset settings: one delimiter, space
    add_row(ty(16'd97, 1'b0, 2'd1, rs(KIND_CHAR, 16'd97), NIL_RES, NIL_RES));
    add_row(ty(16'd32, 1'b0, 2'd1, rs(KIND_TEND, '0), NIL_RES, NIL_RES));
    add_row(ty(16'd32, 1'b0, 2'd0, NIL_RES, NIL_RES, NIL_RES));
    add_row(ty(CU_DQUOTE, 1'b0, 2'd0, NIL_RES, NIL_RES, NIL_RES));
    add_row(pr(16'd32, 1'b0));
    add_row(pr(CU_SQUOTE, 1'b0));
    add_row(ty(CU_BSLASH, 1'b0, 2'd0, NIL_RES, NIL_RES, NIL_RES));
    add_row(pr(CU_DQUOTE, 1'b0));
    add_row(pr(CU_BSLASH, 1'b0));
    add_row(pr(16'd120, 1'b0));
    add_row(pr(CU_DQUOTE, 1'b0));
    add_row(pr(CU_BSLASH, 1'b1));
    add_row(pr(CU_SQUOTE, 1'b0));
    add_row(pr(CU_BSLASH, 1'b0));
    add_row(pr(CU_DQUOTE, 1'b0));
    add_row(ty(16'hFFFF, 1'b1, 2'd3, rs(KIND_CHAR, 16'hFFFF), rs(KIND_TEND, '0),
               rs(KIND_UNMATCHED, '0)));
    add_row(ty(16'h0000, 1'b1, 2'd3, rs(KIND_CHAR, 16'h0000), rs(KIND_TEND, '0),
               rs(KIND_OK, '0)));
    add_row(pr(CU_BSLASH, 1'b0));
    add_row(pr(16'd122, 1'b1));
    add_row(pr(CU_BSLASH, 1'b0));
    add_row(pr(CU_SQUOTE, 1'b0));
    add_row(pr(CU_DQUOTE, 1'b1));
    add_row(ty(CU_DQUOTE, 1'b1, 2'd1, rs(KIND_UNMATCHED, '0), NIL_RES, NIL_RES));
    add_row(ty(16'd32, 1'b1, 2'd1, rs(KIND_OK, '0), NIL_RES, NIL_RES));
    add_row(pr(CU_BSLASH, 1'b0));
    add_row(pr(16'd32, 1'b1));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) send_unit(dir_tab[i].unit, dir_tab[i].fin, i);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain(SETTLE_CYCLES);
        case (p)
          1: begin
            write_reg(REG_DELIM_COUNT, 16'd4);
            write_reg(REG_DELIM_BASE, 16'd32);
            write_reg(REG_DELIM_BASE + 8'd1, 16'd44);
            write_reg(REG_DELIM_BASE + 8'd2, 16'd97);
            write_reg(REG_DELIM_BASE + 8'd3, 16'd9);
          end
          2: write_reg(REG_DELIM_COUNT, 16'd0);
          3: begin
            // count truncates to 7; backslash, quote and both extremes as delimiters
            write_reg(REG_DELIM_COUNT, 16'hFFFF);
            write_reg(REG_DELIM_BASE, CU_BSLASH);
            write_reg(REG_DELIM_BASE + 8'd1, CU_DQUOTE);
            write_reg(REG_DELIM_BASE + 8'd2, 16'h0000);
            write_reg(REG_DELIM_BASE + 8'd3, 16'hFFFF);
          end
          4: begin
            write_reg(REG_DELIM_COUNT, 16'd2);
            write_reg(REG_DELIM_BASE, CU_SQUOTE);
            write_reg(REG_DELIM_BASE + 8'd1, CU_BSLASH);
          end
          5: begin
            write_reg(REG_UNUSED_LOW, CFG_DATA_W'($urandom));
            write_reg(REG_UNUSED_TOP, CFG_DATA_W'($urandom));
            write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LOW + 1, REG_UNUSED_TOP - 1)),
                      CFG_DATA_W'($urandom));
            write_reg(REG_DELIM_COUNT, 16'hFFF3);
            for (int i = 0; i < 3; i++)
              write_reg(REG_DELIM_BASE + CFG_IDX_W'(i), CFG_DATA_W'($urandom_range(33, 126)));
          end
          6: begin
            write_reg(REG_DELIM_COUNT, 16'd4);
            for (int i = 0; i < NUM_DELIM_REGS; i++)
              write_reg(REG_DELIM_BASE + CFG_IDX_W'(i), CFG_DATA_W'($urandom));
          end
          default: begin
            write_reg(REG_DELIM_COUNT, 16'd1);
            write_reg(REG_DELIM_BASE, 16'hFFFF);
          end
        endcase
        n_settings++;
      end
      gaps_on = (p % 4 != 2);
      phase_units = 0;
      paused = 1'b0;
      while (phase_units < PHASE_UNITS) begin
        build_string();
        foreach (str_q[i]) send_unit(str_q[i], i == str_q.size() - 1, -1);
        phase_units += str_q.size();
        if (!paused && phase_units >= PHASE_UNITS / 2) begin
          drain(0);
          paused = 1'b1;
        end
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      n_fail++;
    end
    $display("Covered %0d code units in %0d strings over %0d delimiter settings.",
             n_units, n_strings, n_settings);
    $display("Checked %0d results with %0d mismatches.", n_checked, n_fail);
    if (n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
